// ----- rtl/kmsm_pkg.sv -----
// shared constants, codes and types of the keyed multi-stack manager
`timescale 1ns / 1ps

package kmsm_pkg;

   // table size
   localparam int NUM_STACKS  = 10;
   localparam int STACK_DEPTH = 64;

   // item field widths
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int CAP_W    = 7;
   localparam int IDX_W    = 4;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 7;

   // derived widths
   localparam int SLOT_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int OFS_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int WORDS       = NUM_STACKS * STACK_DEPTH;
   localparam int WORD_ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_GET    = 2'd0,
      CMD_PUSH   = 2'd1,
      CMD_POP    = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_NO_FREE   = 3'd3,
      STAT_BAD_INDEX = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // decision of the descriptor table for the item at the input
   typedef struct packed {
      logic [IDX_W-1:0]       result_index;
      status_type             status;
      logic [DEPTH_W-1:0]     depth_after;
      logic                   mem_we;
      logic                   pop_ok;
      logic [WORD_ADDR_W-1:0] mem_addr;
   } desc_op_type;

endpackage

// ----- rtl/kmsm_if.sv -----
// request and response channel interfaces of the keyed multi-stack manager
`timescale 1ns / 1ps

interface kmsm_req_if import kmsm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [KEY_W-1:0]         stack_key;
   logic [CAP_W-1:0]         requested_capacity;
   logic [IDX_W-1:0]         stack_index;
   logic signed [WORD_W-1:0] push_value;

   modport source (output valid, command, stack_key, requested_capacity, stack_index,
                   push_value, input ready);
   modport sink   (input valid, command, stack_key, requested_capacity, stack_index,
                   push_value, output ready);
endinterface

interface kmsm_rsp_if import kmsm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         result_index;
   logic signed [WORD_W-1:0] popped_value;
   logic [STATUS_W-1:0]      status;
   logic [DEPTH_W-1:0]       depth_after;

   modport source (output valid, result_index, popped_value, status, depth_after,
                   input ready);
   modport sink   (input valid, result_index, popped_value, status, depth_after,
                   output ready);
endinterface

// ----- rtl/keyed_multi_stack_manager.sv -----
// top level of the keyed multi-stack manager: handshake, word memory, response register
`timescale 1ns / 1ps
//
// Keeps up to NUM_STACKS stacks of 32-bit words, each named by a 32-bit key.
// req_ch carries one command per item: get by key (find or claim a slot),
// push, pop or remove on a slot. rsp_ch returns exactly one item per request
// with the slot, the popped word, a status code and the stack depth after.
// Both channels use valid/ready; an item moves when both are high.
// Descriptors sit in flip-flops and are searched in parallel; the stack words
// live in a single-port synchronous memory of NUM_STACKS*STACK_DEPTH words.
// After a request is accepted, the word memory is read into a read register and the
// result then goes into the response register, which turns valid.
// No new request is taken while an item is in its memory read cycle; the next
// request is taken in the same cycle the previous response is taken.
// A stalled receiver holds the response register; requests wait meanwhile.
// Reset (synchronous) frees every slot; the word memory is not cleared and
// needs no clearing pass, so requests are taken right after reset.
//
module keyed_multi_stack_manager import kmsm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   kmsm_req_if.sink   req_ch,
   kmsm_rsp_if.source rsp_ch
);

   logic                  fire;
   desc_op_type           op;
   state_type             state_ff;
   state_type             state_in;

   logic [WORD_W-1:0]     stack_mem [WORDS];
   logic [WORD_W-1:0]     rd_data_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [IDX_W-1:0]      rsp_index_ff;
   logic [WORD_W-1:0]     rsp_value_ff;
   logic [WORD_W-1:0]     rsp_value_in;
   status_type            rsp_status_ff;
   logic [DEPTH_W-1:0]    rsp_depth_ff;
   logic                  pop_ok_ff;

   // request acceptance
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   end
   assign fire = req_ch.valid && req_ch.ready;

   kmsm_desc u_desc (
      .clock              (clock),
      .reset              (reset),
      .fire               (fire),
      .command            (cmd_type'(req_ch.command)),
      .stack_key          (req_ch.stack_key),
      .requested_capacity (req_ch.requested_capacity),
      .stack_index        (req_ch.stack_index),
      .op                 (op)
   );

   // stack word memory, one access per item
   always_ff @(posedge clock) begin
      if (fire && op.mem_we) begin
         stack_mem[op.mem_addr] <= req_ch.push_value;
      end
      rd_data_ff <= stack_mem[op.mem_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid and popped word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = pop_ok_ff ? rd_data_ff : '0;
         end
         ST_IDLE: begin
            if (rsp_valid_ff && rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, captured at acceptance and finished in the read cycle
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      if (fire) begin
         rsp_index_ff  <= op.result_index;
         rsp_status_ff <= op.status;
         rsp_depth_ff  <= op.depth_after;
         pop_ok_ff     <= op.pop_ok;
      end
   end

   // response channel
   always_comb begin
      rsp_ch.valid        = rsp_valid_ff;
      rsp_ch.result_index = rsp_index_ff;
      rsp_ch.popped_value = rsp_value_ff;
      rsp_ch.status       = rsp_status_ff;
      rsp_ch.depth_after  = rsp_depth_ff;
   end

`ifndef SYNTHESIS
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      fire |=> state_ff == ST_READ)
      else $error("accepted item did not enter the read cycle");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("read cycle did not produce a response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("response register still full when a new result lands");

   a_value_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_OK |-> rsp_value_ff == '0)
      else $error("popped word on a failed item");

   a_bad_index_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STAT_BAD_INDEX || rsp_status_ff == STAT_NO_FREE)
      |-> rsp_depth_ff == '0)
      else $error("nonzero depth on a rejected item");
`endif

endmodule

// ----- rtl/kmsm_desc.sv -----
// descriptor table: key search, slot claim and per-slot count bookkeeping
`timescale 1ns / 1ps

module kmsm_desc import kmsm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  cmd_type            command,
   input  logic [KEY_W-1:0]   stack_key,
   input  logic [CAP_W-1:0]   requested_capacity,
   input  logic [IDX_W-1:0]   stack_index,
   output desc_op_type        op
);

   logic               used_ff [NUM_STACKS];
   logic [KEY_W-1:0]   key_ff  [NUM_STACKS];
   logic [CAP_W-1:0]   cap_ff  [NUM_STACKS];
   logic [DEPTH_W-1:0] cnt_ff  [NUM_STACKS];

   logic               used_in [NUM_STACKS];
   logic [KEY_W-1:0]   key_in  [NUM_STACKS];
   logic [CAP_W-1:0]   cap_in  [NUM_STACKS];
   logic [DEPTH_W-1:0] cnt_in  [NUM_STACKS];

   logic               hit_found;
   logic [SLOT_W-1:0]  hit_slot;
   logic               free_found;
   logic [SLOT_W-1:0]  free_slot;
   logic               in_range;
   logic [SLOT_W-1:0]  slot;
   logic               sel_ok;
   logic [DEPTH_W-1:0] cnt;
   logic               full;
   logic               empty;
   logic [CAP_W-1:0]   cap_clamped;
   logic [OFS_W-1:0]   ofs;

   // lowest matching used slot and lowest free slot, searched in parallel
   always_comb begin
      hit_found  = 1'b0;
      hit_slot   = '0;
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NUM_STACKS - 1; i >= 0; i--) begin
         if (used_ff[i] && key_ff[i] == stack_key) begin
            hit_found = 1'b1;
            hit_slot  = SLOT_W'(i);
         end
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   // addressed slot lookup
   assign in_range    = int'(stack_index) < NUM_STACKS;
   assign slot        = stack_index[SLOT_W-1:0];
   assign sel_ok      = in_range && used_ff[slot];
   assign cnt         = cnt_ff[slot];
   assign full        = (cnt >= DEPTH_W'(cap_ff[slot])) || (cnt >= DEPTH_W'(STACK_DEPTH));
   assign empty       = (cnt == '0);
   assign cap_clamped = (requested_capacity > CAP_W'(STACK_DEPTH)) ?
                        CAP_W'(STACK_DEPTH) : requested_capacity;
   assign ofs         = (command == CMD_POP) ? OFS_W'(cnt - DEPTH_W'(1)) : OFS_W'(cnt);

   // result fields and word memory access
   always_comb begin
      op.result_index = stack_index;
      op.status       = STAT_OK;
      op.depth_after  = '0;
      op.mem_we       = 1'b0;
      op.pop_ok       = 1'b0;
      op.mem_addr     = WORD_ADDR_W'(slot) * WORD_ADDR_W'(STACK_DEPTH) + WORD_ADDR_W'(ofs);
      unique case (command)
         CMD_GET: begin
            if (hit_found) begin
               op.result_index = IDX_W'(hit_slot);
               op.depth_after  = cnt_ff[hit_slot];
            end else if (free_found) begin
               op.result_index = IDX_W'(free_slot);
            end else begin
               op.result_index = '0;
               op.status       = STAT_NO_FREE;
            end
         end
         CMD_PUSH: begin
            if (!sel_ok) begin
               op.status = STAT_BAD_INDEX;
            end else if (full) begin
               op.status      = STAT_FULL;
               op.depth_after = cnt;
            end else begin
               op.depth_after = cnt + DEPTH_W'(1);
               op.mem_we      = 1'b1;
            end
         end
         CMD_POP: begin
            if (!sel_ok) begin
               op.status = STAT_BAD_INDEX;
            end else if (empty) begin
               op.status = STAT_EMPTY;
            end else begin
               op.depth_after = cnt - DEPTH_W'(1);
               op.pop_ok      = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (!sel_ok) begin
               op.status = STAT_BAD_INDEX;
            end
         end
         default: begin
            op.status = STAT_BAD_INDEX;
         end
      endcase
   end

   // next descriptor values, one slot touched per item
   always_comb begin
      for (int i = 0; i < NUM_STACKS; i++) begin
         used_in[i] = used_ff[i];
         key_in[i]  = key_ff[i];
         cap_in[i]  = cap_ff[i];
         cnt_in[i]  = cnt_ff[i];
         if (fire) begin
            if (command == CMD_GET && !hit_found && free_found &&
                free_slot == SLOT_W'(i)) begin
               used_in[i] = 1'b1;
               key_in[i]  = stack_key;
               cap_in[i]  = cap_clamped;
               cnt_in[i]  = '0;
            end
            if (sel_ok && slot == SLOT_W'(i)) begin
               if (command == CMD_PUSH && !full) begin
                  cnt_in[i] = cnt + DEPTH_W'(1);
               end
               if (command == CMD_POP && !empty) begin
                  cnt_in[i] = cnt - DEPTH_W'(1);
               end
               if (command == CMD_REMOVE) begin
                  used_in[i] = 1'b0;
                  key_in[i]  = '0;
                  cap_in[i]  = '0;
                  cnt_in[i]  = '0;
               end
            end
         end
      end
   end

   // slot allocation flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            used_ff[i] <= 1'b0;
         end
      end else begin
         used_ff <= used_in;
      end
   end

   // descriptor payload
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      cap_ff <= cap_in;
      cnt_ff <= cnt_in;
   end

endmodule
